>>> rtl/core/sprite_line_evaluator_assert.svh
// Assertion macros for the checker of the sprite line evaluator.
`ifndef SPRITE_LINE_EVALUATOR_ASSERT_SVH
`define SPRITE_LINE_EVALUATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SLE_ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SLE_ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sle_pkg.sv
package sle_pkg;

   localparam int SPRITE_ENTRIES_DEF   = 64;
   localparam int MAX_LINE_SPRITES_DEF = 8;

   localparam int BYTE_W         = 8;
   localparam int BYTES_PER_WORD = 4;
   localparam int WORD_W         = BYTE_W * BYTES_PER_WORD;
   localparam int MEM_WORDS      = 64;
   localparam int WORD_ADDR_W    = 6;
   localparam int LANE_W         = 2;
   localparam int OP_W           = 3;

   localparam logic [OP_W-1:0] OP_SET_ADDR    = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE       = 3'd1;
   localparam logic [OP_W-1:0] OP_READ        = 3'd2;
   localparam logic [OP_W-1:0] OP_EVALUATE    = 3'd3;
   localparam logic [OP_W-1:0] OP_FRAME_START = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESULT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic word_valid;
      logic word_first;
      logic tall;
   } scan_ctrl_type;

   typedef struct packed {
      logic zero_hit;
      logic overflow_hit;
   } scan_stat_type;

endpackage

>>> rtl/core/sle_req_if.sv
interface sle_req_if import sle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] value;
   logic [BYTE_W-1:0] scanline;

   modport source (output valid, operation, value, scanline, input ready);
   modport sink (input valid, operation, value, scanline, output ready);
endinterface

>>> rtl/core/sle_rsp_if.sv
interface sle_rsp_if import sle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic [BYTE_W-1:0] sprite_y;
   logic [BYTE_W-1:0] sprite_tile;
   logic [BYTE_W-1:0] sprite_attr;
   logic [BYTE_W-1:0] sprite_x;
   logic              sprite_valid;
   logic              overflow;
   logic              sprite_zero_on_line;
   logic              last;

   modport source (output valid, read_data, sprite_y, sprite_tile, sprite_attr, sprite_x,
                   sprite_valid, overflow, sprite_zero_on_line, last, input ready);
   modport sink (input valid, read_data, sprite_y, sprite_tile, sprite_attr, sprite_x,
                 sprite_valid, overflow, sprite_zero_on_line, last, output ready);
endinterface

>>> rtl/core/sle_sprite_ram.sv
// Sprite attribute memory: one four-byte entry per word, byte-lane writes.
module sle_sprite_ram import sle_pkg::*; (
   input  logic                   clock,
   input  logic                   write_enable,
   input  logic [WORD_ADDR_W-1:0] write_addr,
   input  logic [LANE_W-1:0]      write_lane,
   input  logic [BYTE_W-1:0]      write_byte,
   input  logic [WORD_ADDR_W-1:0] read_addr,
   output logic [WORD_W-1:0]      read_word
);

   logic [WORD_W-1:0] mem [MEM_WORDS];
   logic [WORD_W-1:0] read_word_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         for (int b = 0; b < BYTES_PER_WORD; b++) begin
            if (write_lane == LANE_W'(b)) begin
               mem[write_addr][b*BYTE_W +: BYTE_W] <= write_byte;
            end
         end
      end
      read_word_ff <= mem[read_addr];
   end

   assign read_word = read_word_ff;

endmodule

>>> rtl/core/sle_scan_unit.sv
// Per-entry range test, found-sprite buffer and overflow byte search.
module sle_scan_unit import sle_pkg::*; #(
   parameter  int MAX_LINE_SPRITES = MAX_LINE_SPRITES_DEF,
   localparam int CNT_W = $clog2(MAX_LINE_SPRITES + 1),
   localparam int IDX_W = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctrl_type     ctrl,
   input  logic [BYTE_W-1:0] scanline,
   input  logic [WORD_W-1:0] word,
   input  logic [IDX_W-1:0]  emit_index,
   output logic [CNT_W-1:0]  count,
   output scan_stat_type     status,
   output logic [WORD_W-1:0] found_word
);

   function automatic logic in_range(logic [BYTE_W-1:0] line, logic [BYTE_W-1:0] y,
                                     logic tall);
      logic [BYTE_W:0] diff;
      diff = {1'b0, line} - {1'b0, y};
      return !diff[BYTE_W] && (tall ? (diff[BYTE_W-1:4] == '0) : (diff[BYTE_W-1:3] == '0));
   endfunction

   logic [WORD_W-1:0] buffer [MAX_LINE_SPRITES];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LANE_W-1:0] byte_sel_ff, byte_sel_in;
   logic              zero_ff, zero_in;
   logic              store;
   logic              overflow_hit;
   logic [BYTE_W-1:0] probe;

   assign probe = word[{byte_sel_ff, 3'b000} +: BYTE_W];

   always_comb begin
      count_in     = count_ff;
      byte_sel_in  = byte_sel_ff;
      zero_in      = zero_ff;
      store        = 1'b0;
      overflow_hit = 1'b0;
      if (ctrl.start) begin
         count_in    = '0;
         byte_sel_in = '0;
         zero_in     = 1'b0;
      end else if (ctrl.word_valid) begin
         if (count_ff < CNT_W'(MAX_LINE_SPRITES)) begin
            if (in_range(scanline, word[BYTE_W-1:0], ctrl.tall)) begin
               store    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (ctrl.word_first) begin
                  zero_in = 1'b1;
               end
            end
         end else if (in_range(scanline, probe, ctrl.tall)) begin
            overflow_hit = 1'b1;
         end else begin
            // Buffer full and a miss: step to the next byte of the next entry.
            byte_sel_in = byte_sel_ff + LANE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         byte_sel_ff <= '0;
         zero_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         byte_sel_ff <= byte_sel_in;
         zero_ff     <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         buffer[count_ff[IDX_W-1:0]] <= word;
      end
   end

   assign count               = count_ff;
   assign found_word          = buffer[emit_index];
   assign status.zero_hit     = zero_ff;
   assign status.overflow_hit = overflow_hit;

endmodule

>>> rtl/core/sprite_line_evaluator.sv
// Channel   | Direction | Handshake           | Payload
// req_chan  | in        | valid/ready         | operation, value, scanline
// rsp_chan  | out       | valid/ready         | read_data, sprite bytes, flags, last
// csr       | in        | csr_write_enable    | csr_write_data (tall_sprites)
//
// One transaction at a time. Set address, write, read, frame start and unused codes
// pass through ST_RESULT, which loads the result register once it is free.
// Line evaluation reads and tests each of the SPRITE_ENTRIES memory entries in turn,
// then emits its results (1 to MAX_LINE_SPRITES) one after another while rsp_chan is ready.
// Reset is synchronous and clears pointer, overflow flag and control; memory is not
// cleared. A stalled rsp_chan holds its result; a new request is taken while it waits.
module sprite_line_evaluator import sle_pkg::*; #(
   parameter int SPRITE_ENTRIES   = SPRITE_ENTRIES_DEF,
   parameter int MAX_LINE_SPRITES = MAX_LINE_SPRITES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sle_req_if.sink    req_chan,
   sle_rsp_if.source  rsp_chan,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   localparam int ENTRY_W = $clog2(SPRITE_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_LINE_SPRITES + 1);
   localparam int IDX_W   = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
   localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(SPRITE_ENTRIES - 1);

   // Control state
   state_type          state_ff, state_in;
   logic [BYTE_W-1:0]  pointer_ff, pointer_in;
   logic               overflow_ff, overflow_in;
   logic               tall_ff, tall_in;
   logic [ENTRY_W-1:0] issue_n_ff, issue_n_in;
   logic               issue_done_ff, issue_done_in;
   logic               proc_valid_ff, proc_valid_in;
   logic [ENTRY_W-1:0] proc_n_ff, proc_n_in;
   logic               is_read_ff, is_read_in;
   logic [CNT_W-1:0]   emit_idx_ff, emit_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [BYTE_W-1:0]  scanline_ff, scanline_in;
   logic [BYTE_W-1:0]  rd_ff, rd_in;
   logic [WORD_W-1:0]  sprite_ff, sprite_in;
   logic               sprite_valid_ff, sprite_valid_in;
   logic               ovf_out_ff, ovf_out_in;
   logic               zero_out_ff, zero_out_in;
   logic               last_ff, last_in;

   logic                   accept;
   logic                   slot_free;
   logic                   emit_last;
   logic                   mem_write;
   logic [WORD_ADDR_W-1:0] read_addr;
   logic [WORD_W-1:0]      ram_word;
   scan_ctrl_type          scan_ctrl;
   scan_stat_type          scan_stat;
   logic [CNT_W-1:0]       found_count;
   logic [WORD_W-1:0]      found_word;

   sle_sprite_ram u_ram (
      .clock        (clock),
      .write_enable (mem_write),
      .write_addr   (pointer_ff[BYTE_W-1:LANE_W]),
      .write_lane   (pointer_ff[LANE_W-1:0]),
      .write_byte   (req_chan.value),
      .read_addr    (read_addr),
      .read_word    (ram_word)
   );

   sle_scan_unit #(
      .MAX_LINE_SPRITES (MAX_LINE_SPRITES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .scanline   (scanline_ff),
      .word       (ram_word),
      .emit_index (emit_idx_ff[IDX_W-1:0]),
      .count      (found_count),
      .status     (scan_stat),
      .found_word (found_word)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   // The result register frees when empty or when its transaction completes.
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign emit_last      = (found_count == '0) || (emit_idx_ff == found_count - CNT_W'(1));
   assign tall_in        = csr_write_enable ? csr_write_data : tall_ff;

   always_comb begin
      state_in        = state_ff;
      pointer_in      = pointer_ff;
      overflow_in     = overflow_ff;
      issue_n_in      = issue_n_ff;
      issue_done_in   = issue_done_ff;
      proc_valid_in   = 1'b0;
      proc_n_in       = proc_n_ff;
      is_read_in      = is_read_ff;
      emit_idx_in     = emit_idx_ff;
      scanline_in     = scanline_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rd_in           = rd_ff;
      sprite_in       = sprite_ff;
      sprite_valid_in = sprite_valid_ff;
      ovf_out_in      = ovf_out_ff;
      zero_out_in     = zero_out_ff;
      last_in         = last_ff;
      mem_write       = 1'b0;
      // Outside a scan, keep the word under the pointer in the memory output.
      read_addr       = pointer_ff[BYTE_W-1:LANE_W];
      scan_ctrl       = '{start: 1'b0, word_valid: 1'b0, word_first: 1'b0, tall: tall_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               is_read_in = 1'b0;
               state_in   = ST_RESULT;
               unique case (req_chan.operation)
                  OP_SET_ADDR: begin
                     pointer_in = req_chan.value;
                  end
                  OP_WRITE: begin
                     mem_write  = 1'b1;
                     pointer_in = pointer_ff + BYTE_W'(1);
                  end
                  OP_READ: begin
                     is_read_in = 1'b1;
                  end
                  OP_EVALUATE: begin
                     scanline_in     = req_chan.scanline;
                     issue_n_in      = '0;
                     issue_done_in   = 1'b0;
                     scan_ctrl.start = 1'b1;
                     state_in        = ST_SCAN;
                  end
                  OP_FRAME_START: begin
                     overflow_in = 1'b0;
                  end
                  default: begin
                     // Unused codes: answer with an empty result and change nothing.
                  end
               endcase
            end
         end

         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rd_in           = is_read_ff ? ram_word[{pointer_ff[LANE_W-1:0], 3'b000} +: BYTE_W]
                                            : '0;
               sprite_in       = '0;
               sprite_valid_in = 1'b0;
               ovf_out_in      = overflow_ff;
               zero_out_in     = 1'b0;
               last_in         = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // Issue one entry read a cycle; the word is tested in the next cycle.
            read_addr     = WORD_ADDR_W'(issue_n_ff);
            proc_valid_in = !issue_done_ff;
            proc_n_in     = issue_n_ff;
            if (!issue_done_ff) begin
               issue_n_in = issue_n_ff + ENTRY_W'(1);
               if (issue_n_ff == ENTRY_LAST) begin
                  issue_done_in = 1'b1;
               end
            end
            scan_ctrl.word_valid = proc_valid_ff;
            scan_ctrl.word_first = (proc_n_ff == '0);
            if (scan_stat.overflow_hit) begin
               overflow_in = 1'b1;
            end
            if (proc_valid_ff && (proc_n_ff == ENTRY_LAST)) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rd_in           = '0;
               sprite_in       = (found_count != '0) ? found_word : '0;
               sprite_valid_in = (found_count != '0);
               ovf_out_in      = overflow_ff;
               zero_out_in     = scan_stat.zero_hit;
               last_in         = emit_last;
               emit_idx_in     = emit_idx_ff + CNT_W'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pointer_ff    <= '0;
         overflow_ff   <= 1'b0;
         tall_ff       <= 1'b0;
         issue_n_ff    <= '0;
         issue_done_ff <= 1'b0;
         proc_valid_ff <= 1'b0;
         proc_n_ff     <= '0;
         is_read_ff    <= 1'b0;
         emit_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pointer_ff    <= pointer_in;
         overflow_ff   <= overflow_in;
         tall_ff       <= tall_in;
         issue_n_ff    <= issue_n_in;
         issue_done_ff <= issue_done_in;
         proc_valid_ff <= proc_valid_in;
         proc_n_ff     <= proc_n_in;
         is_read_ff    <= is_read_in;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scanline_ff     <= scanline_in;
      rd_ff           <= rd_in;
      sprite_ff       <= sprite_in;
      sprite_valid_ff <= sprite_valid_in;
      ovf_out_ff      <= ovf_out_in;
      zero_out_ff     <= zero_out_in;
      last_ff         <= last_in;
   end

   // Sprite bytes sit in memory order: Y, tile, attribute, X.
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.read_data           = rd_ff;
   assign rsp_chan.sprite_y            = sprite_ff[0*BYTE_W +: BYTE_W];
   assign rsp_chan.sprite_tile         = sprite_ff[1*BYTE_W +: BYTE_W];
   assign rsp_chan.sprite_attr         = sprite_ff[2*BYTE_W +: BYTE_W];
   assign rsp_chan.sprite_x            = sprite_ff[3*BYTE_W +: BYTE_W];
   assign rsp_chan.sprite_valid        = sprite_valid_ff;
   assign rsp_chan.overflow            = ovf_out_ff;
   assign rsp_chan.sprite_zero_on_line = zero_out_ff;
   assign rsp_chan.last                = last_ff;

endmodule

>>> rtl/core/sle_checker.sv
`include "sprite_line_evaluator_assert.svh"

module sle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] read_data,
   input logic [7:0] sprite_y,
   input logic [7:0] sprite_tile,
   input logic [7:0] sprite_attr,
   input logic [7:0] sprite_x,
   input logic       sprite_valid,
   input logic       overflow,
   input logic       sprite_zero_on_line,
   input logic       last
);

   logic in_burst_ff, in_burst_in;
   logic burst_zero_ff, burst_zero_in;
   logic burst_ovf_ff, burst_ovf_in;

   // Track the flags of an evaluation whose results are still being delivered.
   always_comb begin
      in_burst_in   = in_burst_ff;
      burst_zero_in = burst_zero_ff;
      burst_ovf_in  = burst_ovf_ff;
      if (rsp_valid && rsp_ready) begin
         in_burst_in   = !last;
         burst_zero_in = sprite_zero_on_line;
         burst_ovf_in  = overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_burst_ff   <= 1'b0;
         burst_zero_ff <= 1'b0;
         burst_ovf_ff  <= 1'b0;
      end else begin
         in_burst_ff   <= in_burst_in;
         burst_zero_ff <= burst_zero_in;
         burst_ovf_ff  <= burst_ovf_in;
      end
   end

   `SLE_ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(read_data) && $stable(sprite_y) && $stable(sprite_tile)
         && $stable(sprite_attr) && $stable(sprite_x) && $stable(last),
      "stalled result changed")

   `SLE_ASSERT_SAME_CYCLE(a_burst_carries_sprite, clock, reset, rsp_valid && in_burst_ff,
      sprite_valid, "continuation of a line result carries no sprite")

   `SLE_ASSERT_SAME_CYCLE(a_burst_flags_steady, clock, reset, rsp_valid && in_burst_ff,
      (sprite_zero_on_line == burst_zero_ff) && (overflow == burst_ovf_ff),
      "flags changed within one line result")

   `SLE_ASSERT_NEXT_CYCLE(a_reset_empties_output, clock, 1'b0, reset,
      !rsp_valid, "result pending after reset")

endmodule

bind sprite_line_evaluator sle_checker u_sle_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .read_data           (rsp_chan.read_data),
   .sprite_y            (rsp_chan.sprite_y),
   .sprite_tile         (rsp_chan.sprite_tile),
   .sprite_attr         (rsp_chan.sprite_attr),
   .sprite_x            (rsp_chan.sprite_x),
   .sprite_valid        (rsp_chan.sprite_valid),
   .overflow            (rsp_chan.overflow),
   .sprite_zero_on_line (rsp_chan.sprite_zero_on_line),
   .last                (rsp_chan.last)
);

>>> dv/sprite_line_evaluator_tb.sv
module sprite_line_evaluator_tb;
   import sle_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Operation codes the block has no use for; they must come back as a plain result.
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   localparam int MEM_BYTES    = 2 ** BYTE_W;
   localparam int RANDOM_ITEMS = 100;
   localparam int REPORT_LIMIT = 10;
   // Y offset spread below a target line: up to 17, past the height of a tall sprite.
   localparam int Y_SPREAD     = 17;
   // Evaluation walks every entry once, plus a little slack for the result register.
   localparam int SETTLE_CYCLES = SPRITE_ENTRIES_DEF + 8;

   localparam logic [BYTE_W-1:0] VISIBLE_LAST   = 8'd239;
   localparam logic [BYTE_W-1:0] OFFSCREEN_Y    = 8'd240;
   localparam logic [BYTE_W-1:0] CROWD_Y        = 8'd100;  // entries 0 to 7
   localparam logic [BYTE_W-1:0] LATE_Y         = 8'd104;  // entry 8
   localparam logic [BYTE_W-1:0] HEIGHT_Y       = 8'd10;   // entry 0 in the height test
   localparam int                CROWD_ENTRIES  = 8;
   localparam int                LATE_ENTRY     = 8;
   localparam int                QUIRK_ENTRY    = 9;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic [BYTE_W-1:0] y;
      logic [BYTE_W-1:0] tile;
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] x;
      logic              sprite_valid;
      logic              overflow;
      logic              zero_on_line;
      logic              last;
   } sprite_result_type;

   bit   clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   sle_req_if req_bus ();
   sle_rsp_if rsp_bus ();

   sprite_line_evaluator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus.sink),
      .rsp_chan         (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of everything the block remembers.
   logic [BYTE_W-1:0] shadow_mem [MEM_BYTES];
   logic [BYTE_W-1:0] shadow_pointer;
   logic              shadow_overflow;
   logic              shadow_tall;

   // Results still owed by the block, oldest first.
   sprite_result_type due_responses[$];

   bit          sender_idles;
   bit          sink_idles;
   int unsigned sink_hold;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned eval_count;
   int unsigned overflow_evals;
   int unsigned tall_writes;
   int unsigned error_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [BYTE_W-1:0] any_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic string show_result(sprite_result_type r);
      return $sformatf("rd=%h y=%h tile=%h attr=%h x=%h valid=%b ovf=%b zero=%b last=%b",
                       r.read_data, r.y, r.tile, r.attr, r.x, r.sprite_valid, r.overflow,
                       r.zero_on_line, r.last);
   endfunction

   function automatic void report_failure(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endfunction

   function automatic bit on_line(logic [BYTE_W-1:0] line, logic [BYTE_W-1:0] y);
      int diff;
      diff = int'(line) - int'(y);
      return diff >= 0 && diff < (shadow_tall ? 16 : 8);
   endfunction

   // Append one owed result behind the ones already waiting.
   function automatic void owe_result(sprite_result_type r);
      due_responses = {due_responses, r};
   endfunction

   // Work out what the block owes for one accepted transaction and queue it.
   function automatic void predict_sprite_response(logic [OP_W-1:0]   op,
                                                   logic [BYTE_W-1:0] value,
                                                   logic [BYTE_W-1:0] line);
      sprite_result_type r;
      logic [BYTE_W-1:0] hit_bytes [MAX_LINE_SPRITES_DEF][BYTES_PER_WORD];
      logic [BYTE_W-1:0] base;
      int                found;
      int unsigned       lane;
      bit                zero_hit;
      r        = '0;
      r.last   = 1'b1;
      found    = 0;
      lane     = 0;
      zero_hit = 1'b0;
      case (op)
         OP_SET_ADDR: begin
            shadow_pointer = value;
         end
         OP_WRITE: begin
            shadow_mem[shadow_pointer] = value;
            shadow_pointer++;
         end
         OP_READ: begin
            r.read_data = shadow_mem[shadow_pointer];
         end
         OP_EVALUATE: begin
            for (int n = 0; n < SPRITE_ENTRIES_DEF; n++) begin
               base = BYTE_W'(n * BYTES_PER_WORD);
               if (found < MAX_LINE_SPRITES_DEF) begin
                  if (on_line(line, shadow_mem[base])) begin
                     for (int b = 0; b < BYTES_PER_WORD; b++) begin
                        hit_bytes[found][b] = shadow_mem[BYTE_W'(base + b)];
                     end
                     if (n == 0) begin
                        zero_hit = 1'b1;
                     end
                     found++;
                  end
               end else if (on_line(line, shadow_mem[BYTE_W'(base + lane)])) begin
                  shadow_overflow = 1'b1;
               end else begin
                  // hardware slip: a miss moves the tested byte along the entry
                  lane = (lane + 1) % BYTES_PER_WORD;
               end
            end
            eval_count++;
            if (shadow_overflow) begin
               overflow_evals++;
            end
            r.overflow     = shadow_overflow;
            r.zero_on_line = zero_hit;
            if (found == 0) begin
               owe_result(r);
            end
            for (int k = 0; k < found; k++) begin
               r.sprite_valid = 1'b1;
               r.y            = hit_bytes[k][0];
               r.tile         = hit_bytes[k][1];
               r.attr         = hit_bytes[k][2];
               r.x            = hit_bytes[k][3];
               r.last         = (k == found - 1);
               owe_result(r);
            end
            return;
         end
         OP_FRAME_START: begin
            shadow_overflow = 1'b0;
         end
         default: begin
         end
      endcase
      r.overflow = shadow_overflow;
      owe_result(r);
   endfunction

   // Offer one transaction after a random gap and hold it until the block takes it.
   task automatic send_item(input logic [OP_W-1:0]   op,
                            input logic [BYTE_W-1:0] value,
                            input logic [BYTE_W-1:0] line);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= value;
      req_bus.scanline  <= line;
      @(posedge clock iff (req_bus.ready === 1'b1));
      sent_count++;
      predict_sprite_response(op, value, line);
   endtask

   // Drop valid and hold off until every owed result has been taken.
   task automatic wait_until_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (due_responses.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_tall(input logic tall);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= tall;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_tall = tall;
      tall_writes++;
   endtask

   // Write all 256 bytes so that nothing read later is undefined. Entries 0 to 7 sit on
   // CROWD_Y, entry 8 on LATE_Y, entry 9 carries CROWD_Y in its tile byte for the
   // shifted-byte search; every other Y byte is parked below the visible lines.
   task automatic test_fill_sprite_memory();
      logic [BYTE_W-1:0] data;
      send_item(OP_SET_ADDR, 8'h00, any_byte());
      for (int a = 0; a < MEM_BYTES; a++) begin
         if (a % BYTES_PER_WORD != 0) begin
            data = any_byte();
         end else if (a / BYTES_PER_WORD < CROWD_ENTRIES) begin
            data = CROWD_Y;
         end else if (a / BYTES_PER_WORD == LATE_ENTRY) begin
            data = LATE_Y;
         end else begin
            data = BYTE_W'($urandom_range(OFFSCREEN_Y, MEM_BYTES - 1));
         end
         if (a == QUIRK_ENTRY * BYTES_PER_WORD + 1) begin
            data = CROWD_Y;
         end
         send_item(OP_WRITE, data, any_byte());
      end
      // pointer has wrapped back to the first byte
      send_item(OP_READ, any_byte(), any_byte());
   endtask

   task automatic test_pointer_access();
      send_item(OP_SET_ADDR, 8'hFF, any_byte());
      send_item(OP_WRITE, 8'h00, any_byte());
      send_item(OP_READ, any_byte(), any_byte());
      send_item(OP_SET_ADDR, 8'hFF, any_byte());
      send_item(OP_READ, any_byte(), any_byte());
      send_item(OP_SET_ADDR, 8'h80, any_byte());
      send_item(OP_WRITE, 8'hFF, any_byte());
      send_item(OP_SET_ADDR, 8'h80, any_byte());
      send_item(OP_READ, any_byte(), any_byte());
   endtask

   task automatic test_overflow_search();
      send_item(OP_FRAME_START, any_byte(), any_byte());
      // eight found, entry 8 misses, the slipped search then hits entry 9's tile byte
      send_item(OP_EVALUATE, any_byte(), CROWD_Y);
      // empty line: the flag must stay set
      send_item(OP_EVALUATE, any_byte(), CROWD_Y - 8'd40);
      send_item(OP_UNUSED_FIRST, any_byte(), any_byte());
      send_item(OP_FRAME_START, any_byte(), any_byte());
      // a genuine ninth sprite
      send_item(OP_EVALUATE, any_byte(), LATE_Y);
      send_item(OP_FRAME_START, any_byte(), any_byte());
      // beyond the visible lines the parked Y bytes come into range
      send_item(OP_EVALUATE, any_byte(), 8'hFF);
      send_item(OP_EVALUATE, any_byte(), 8'h00);
      send_item(OP_EVALUATE, any_byte(), VISIBLE_LAST);
      send_item(OP_FRAME_START, any_byte(), any_byte());
   endtask

   task automatic test_sprite_height();
      send_item(OP_SET_ADDR, 8'h00, any_byte());
      send_item(OP_WRITE, HEIGHT_Y, any_byte());
      repeat (BYTES_PER_WORD - 1) send_item(OP_WRITE, any_byte(), any_byte());
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y - 8'd1);
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y);
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y + 8'd7);
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y + 8'd8);
      wait_until_idle();
      write_tall(1'b1);
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y + 8'd8);
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y + 8'd15);
      send_item(OP_EVALUATE, any_byte(), HEIGHT_Y + 8'd16);
      wait_until_idle();
      write_tall(1'b0);
   endtask

   task automatic test_unused_codes();
      for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
         send_item(OP_W'(code), any_byte(), any_byte());
      end
   endtask

   function automatic logic [BYTE_W-1:0] pick_line();
      if ($urandom_range(0, 7) == 0) begin
         return BYTE_W'($urandom_range(VISIBLE_LAST + 1, MEM_BYTES - 1));
      end
      return BYTE_W'($urandom_range(0, VISIBLE_LAST));
   endfunction

   // Mostly sprite scenes: crowd a line with fresh entries, then evaluate around it.
   // Reusing the line often lets entries pile up past eight. The rest is noise.
   task automatic test_random_traffic();
      int unsigned       first_sent;
      int unsigned       kind;
      logic [BYTE_W-1:0] target;
      first_sent = sent_count;
      target     = pick_line();
      while (sent_count - first_sent < RANDOM_ITEMS) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         sink_idles   = ($urandom_range(0, 3) != 0);
         kind         = $urandom_range(0, 9);
         if (kind < 6) begin
            if ($urandom_range(0, 1) == 0) begin
               target = pick_line();
            end
            send_item(OP_SET_ADDR,
                      BYTE_W'($urandom_range(0, SPRITE_ENTRIES_DEF - 1) * BYTES_PER_WORD),
                      any_byte());
            repeat ($urandom_range(1, 10)) begin
               send_item(OP_WRITE, target - BYTE_W'($urandom_range(0, Y_SPREAD)), any_byte());
               repeat (BYTES_PER_WORD - 1) send_item(OP_WRITE, any_byte(), any_byte());
            end
            repeat ($urandom_range(1, 3)) begin
               send_item(OP_EVALUATE, any_byte(),
                         target + BYTE_W'($urandom_range(0, 4)) - 8'd2);
            end
         end else if (kind == 6) begin
            send_item(OP_SET_ADDR, any_byte(), any_byte());
            if ($urandom_range(0, 1) == 0) begin
               send_item(OP_WRITE, any_byte(), any_byte());
            end
            send_item(OP_READ, any_byte(), any_byte());
         end else if (kind == 7) begin
            send_item(OP_FRAME_START, any_byte(), any_byte());
         end else if (kind == 8) begin
            send_item(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), any_byte(),
                      any_byte());
         end else begin
            wait_until_idle();
            write_tall(1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic finish_run();
      wait_until_idle();
      // give a stray result the length of a full evaluation to show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_responses.size() != 0) begin
         report_failure($sformatf("%0d results never arrived", due_responses.size()));
      end
      $display("Sent %0d transactions including %0d line evaluations (%0d with overflow set).",
               sent_count, eval_count, overflow_evals);
      $display("Checked %0d results across %0d sprite height settings; %0d failures.",
               checked_count, tall_writes, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   endtask

   // Compare every accepted result with the oldest owed one; draw the next stall.
   always @(posedge clock) begin : response_check
      sprite_result_type got;
      sprite_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.read_data    = rsp_bus.read_data;
         got.y            = rsp_bus.sprite_y;
         got.tile         = rsp_bus.sprite_tile;
         got.attr         = rsp_bus.sprite_attr;
         got.x            = rsp_bus.sprite_x;
         got.sprite_valid = rsp_bus.sprite_valid;
         got.overflow     = rsp_bus.overflow;
         got.zero_on_line = rsp_bus.sprite_zero_on_line;
         got.last         = rsp_bus.last;
         if (due_responses.size() == 0) begin
            report_failure({"result with nothing outstanding: ", show_result(got)});
         end else begin
            want = due_responses.pop_front();
            if (got !== want) begin
               report_failure($sformatf("result %0d mismatch\n   expected %s\n   actual   %s",
                                        checked_count, show_result(want), show_result(got)));
            end
         end
         checked_count++;
         sink_hold <= sink_idles ? $urandom_range(0, 3) : 0;
      end
   end

   // Hold ready low for the drawn number of cycles after each transaction.
   always @(negedge clock) begin
      rsp_bus.ready <= (sink_hold == 0);
      if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_SET_ADDR;
      req_bus.value     = '0;
      req_bus.scanline  = '0;
      rsp_bus.ready     = 1'b0;
      shadow_pointer    = '0;
      shadow_overflow   = 1'b0;
      shadow_tall       = 1'b0;
      sender_idles      = 1'b1;
      sink_idles        = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_tall(1'b0);
      test_fill_sprite_memory();
      test_pointer_access();
      test_overflow_search();
      test_sprite_height();
      test_unused_codes();
      wait_until_idle();
      write_tall(1'b1);
      test_random_traffic();
      finish_run();
   end

   // Far beyond the slowest legal run; a hang ends here.
   initial begin
      #1_000_000;
      $display("[%0t] ERROR: time limit reached with %0d results outstanding",
               $realtime, due_responses.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_req_if.sv
rtl/core/sle_rsp_if.sv
rtl/core/sle_sprite_ram.sv
rtl/core/sle_scan_unit.sv
rtl/core/sprite_line_evaluator.sv
rtl/core/sle_checker.sv
dv/sprite_line_evaluator_tb.sv
